// ----- rtl/gfm_pkg.sv -----
// ----------------------------------------------------------------------------
// gfm_pkg: shared types, constants and step functions
// Field sizes, pipeline split, register indexes and the per-stage bit
// steps of the Galois field multiplier.
// ----------------------------------------------------------------------------
package gfm_pkg;

   localparam int WIDE_BYTES      = 16;
   localparam int WIDE_BITS       = WIDE_BYTES * 8;
   localparam int HALF_BITS       = WIDE_BITS / 2;
   localparam int BYTE_BITS       = 8;
   localparam int STEPS_PER_STAGE = 8;
   localparam int NUM_STAGES      = WIDE_BITS / STEPS_PER_STAGE;
   localparam int CSR_IDX_BITS    = 2;

   localparam logic [HALF_BITS-1:0] POLY_HI_RESET = 64'hE100_0000_0000_0000;
   localparam logic [HALF_BITS-1:0] POLY_LO_RESET = '0;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FIELD_MODE = 2'd0,
      CSR_POLY_HI    = 2'd1,
      CSR_POLY_LO    = 2'd2
   } csr_index_type;

   typedef logic [WIDE_BITS-1:0] wide_type;

   // one item in flight
   typedef struct packed {
      wide_type             x;
      wide_type             y;
      wide_type             acc;
      logic                 mode;
      logic [BYTE_BITS-1:0] prod8;
   } stage_type;

   // GF(2^8) product: scan b from bit 0, shift a left, reduce on overflow
   function automatic logic [BYTE_BITS-1:0] byte_mul(
      input logic [BYTE_BITS-1:0] a_in,
      input logic [BYTE_BITS-1:0] b,
      input logic [BYTE_BITS-1:0] p
   );
      logic [BYTE_BITS-1:0] a;
      logic [BYTE_BITS-1:0] acc;
      logic                 top;
      a   = a_in;
      acc = '0;
      for (int k = 0; k < BYTE_BITS; k++) begin
         if (b[k]) acc = acc ^ a;
         top = a[BYTE_BITS-1];
         a   = {a[BYTE_BITS-2:0], 1'b0};
         if (top) a = a ^ p;
      end
      return acc;
   endfunction

   // one stage's worth of reflected GF(2^128) steps: consume y from the top
   function automatic stage_type wide_steps(
      input stage_type s_in,
      input wide_type  poly
   );
      stage_type s;
      logic      low;
      s = s_in;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
         if (s.y[WIDE_BITS-1]) s.acc = s.acc ^ s.x;
         low = s.x[0];
         s.x = s.x >> 1;
         if (low) s.x = s.x ^ poly;
         s.y = s.y << 1;
      end
      return s;
   endfunction

endpackage

// ----- rtl/gfm_req_if.sv -----
// ----------------------------------------------------------------------------
// gfm_req_if: operand channel
// Valid/ready channel carrying both 128-bit operands as two halves each.
// ----------------------------------------------------------------------------
interface gfm_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] x_hi;
   logic [63:0] x_lo;
   logic [63:0] y_hi;
   logic [63:0] y_lo;

   modport source (output valid, output x_hi, output x_lo, output y_hi, output y_lo,
                   input ready);
   modport sink   (input valid, input x_hi, input x_lo, input y_hi, input y_lo,
                   output ready);
endinterface

// ----- rtl/gfm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gfm_rsp_if: product channel
// Valid/ready channel carrying the 128-bit field product as two halves.
// ----------------------------------------------------------------------------
interface gfm_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] prod_hi;
   logic [63:0] prod_lo;

   modport source (output valid, output prod_hi, output prod_lo, input ready);
   modport sink   (input valid, input prod_hi, input prod_lo, output ready);
endinterface

// ----- rtl/galois_field_multiplier.sv -----
// ----------------------------------------------------------------------------
// galois_field_multiplier: pipelined GF(2^8) / GF(2^128) multiplier
// Carry-less field product, byte mode (AES) or bit-reflected wide mode
// (GHASH), polynomial and mode set through the CSR port.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  req_bus  | in        | valid/ready      | x_hi, x_lo, y_hi, y_lo
//  rsp_bus  | out       | valid/ready      | prod_hi, prod_lo
//  csr_*    | in        | csr_wr_en only   | csr_index, csr_wr_data
//
// The 128 wide-mode bit steps run 8 per register stage over 16 stages; byte
// mode is done in the first stage and rides along. Unless the product channel
// stalls, one item per cycle is accepted and one product per cycle is delivered.
// Each stage holds its item while the stage after it cannot load, so an item is
// accepted whenever the first stage frees up, even while a product waits.
// Synchronous reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module galois_field_multiplier (
   input  logic                                 clock,
   input  logic                                 reset,
   gfm_req_if.sink                              req_bus,
   gfm_rsp_if.source                            rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [gfm_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [gfm_pkg::HALF_BITS-1:0]        csr_wr_data
);

   localparam int NS = gfm_pkg::NUM_STAGES;
   localparam int HB = gfm_pkg::HALF_BITS;
   localparam int BB = gfm_pkg::BYTE_BITS;

   // configuration
   logic          field_mode_ff;
   logic [HB-1:0] poly_hi_ff;
   logic [HB-1:0] poly_lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_mode_ff <= 1'b1;
         poly_hi_ff    <= gfm_pkg::POLY_HI_RESET;
         poly_lo_ff    <= gfm_pkg::POLY_LO_RESET;
      end else if (csr_wr_en) begin
         case (gfm_pkg::csr_index_type'(csr_index))
            gfm_pkg::CSR_FIELD_MODE: field_mode_ff <= csr_wr_data[0];
            gfm_pkg::CSR_POLY_HI:    poly_hi_ff    <= csr_wr_data;
            gfm_pkg::CSR_POLY_LO:    poly_lo_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   gfm_pkg::wide_type poly;
   assign poly = {poly_hi_ff, poly_lo_ff};

   // pipeline
   gfm_pkg::stage_type stage_ff  [NS];
   gfm_pkg::stage_type stage_in  [NS];
   gfm_pkg::stage_type entry;
   logic [NS-1:0]      valid_ff;
   logic [NS-1:0]      valid_in;
   logic [NS-1:0]      stage_rdy;

   always_comb begin
      entry.x     = {req_bus.x_hi, req_bus.x_lo};
      entry.y     = {req_bus.y_hi, req_bus.y_lo};
      entry.acc   = '0;
      entry.mode  = field_mode_ff;
      entry.prod8 = gfm_pkg::byte_mul(req_bus.x_lo[BB-1:0], req_bus.y_lo[BB-1:0],
                                      poly_lo_ff[BB-1:0]);
   end

   // a stage may load when it is empty or its item moves on
   always_comb begin
      stage_rdy[NS-1] = !valid_ff[NS-1] || rsp_bus.ready;
      for (int s = NS - 2; s >= 0; s--) begin
         stage_rdy[s] = !valid_ff[s] || stage_rdy[s+1];
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      if (s == 0) begin : g_first
         always_comb begin
            stage_in[s] = gfm_pkg::wide_steps(entry, poly);
            valid_in[s] = req_bus.valid;
         end
      end else begin : g_next
         always_comb begin
            stage_in[s] = gfm_pkg::wide_steps(stage_ff[s-1], poly);
            valid_in[s] = valid_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stage_rdy[s]) begin
            valid_ff[s] <= valid_in[s];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_rdy[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign req_bus.ready   = stage_rdy[0];
   assign rsp_bus.valid   = valid_ff[NS-1];
   assign rsp_bus.prod_hi = stage_ff[NS-1].mode ? stage_ff[NS-1].acc[2*HB-1:HB] : '0;
   assign rsp_bus.prod_lo = stage_ff[NS-1].mode ? stage_ff[NS-1].acc[HB-1:0]
                                                : {{(HB-BB){1'b0}}, stage_ff[NS-1].prod8};

   // assertions
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input accepted into a full, stalled pipeline");

   a_accept_fills_first: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> valid_ff[0])
      else $error("accepted item did not land in the first stage");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[0] && !stage_rdy[0]) |=> (valid_ff[0] && $stable(stage_ff[0])))
      else $error("stalled first stage lost or changed its item");

   a_byte_mode_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !stage_ff[NS-1].mode) |->
         (rsp_bus.prod_hi == '0 && rsp_bus.prod_lo[HB-1:BB] == '0))
      else $error("byte-mode product has nonzero upper bits");

endmodule

// ----- tb/sv/tb_galois_field_multiplier.sv -----
// ----------------------------------------------------------------------------
// tb_galois_field_multiplier: self-checking bench for the field multiplier
// Sends directed and random operand pairs in byte and wide mode under a range
// of polynomials, with random stalls on both channels. A scoreboard computes
// each field product on acceptance and checks the products in order.
// ----------------------------------------------------------------------------
module tb_galois_field_multiplier;

   localparam int CLOCK_HALF         = 6;
   localparam int RESET_CYCLES       = 8;
   localparam int PIPE_LATENCY       = 16;
   localparam int SETTLE_CYCLES      = PIPE_LATENCY + 8;
   localparam int RANDOM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE    = 240;
   localparam int CYCLE_LIMIT        = 300000;
   localparam logic [gfm_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam logic [63:0] GHASH_POLY_HI = 64'hE100_0000_0000_0000;
   localparam logic [63:0] AES_POLY_LO   = 64'h0000_0000_0000_001B;

   // product predictor and in-order store of expected products
   class gf_product_board;
      bit          wide_mode;
      bit [127:0]  poly;
      bit [127:0]  expected_products[$];
      int          errors;

      function new();
         wide_mode = 1'b1;
         poly      = {gfm_pkg::POLY_HI_RESET, gfm_pkg::POLY_LO_RESET};
         errors    = 0;
      endfunction

      function void set_reg(logic [gfm_pkg::CSR_IDX_BITS-1:0] idx, logic [63:0] value);
         case (idx)
            gfm_pkg::CSR_FIELD_MODE: wide_mode     = value[0];
            gfm_pkg::CSR_POLY_HI:    poly[127:64]  = value;
            gfm_pkg::CSR_POLY_LO:    poly[63:0]    = value;
            default: ;
         endcase
      endfunction

      function bit [127:0] field_product(bit [127:0] x, bit [127:0] y);
         bit [127:0] xs;
         bit [127:0] acc;
         bit [7:0]   a8;
         bit [7:0]   acc8;
         bit         carry;
         acc  = '0;
         acc8 = '0;
         if (!wide_mode) begin
            a8 = x[7:0];
            for (int k = 0; k < 8; k++) begin
               if (y[k]) acc8 ^= a8;
               carry = a8[7];
               a8    = a8 << 1;
               if (carry) a8 ^= poly[7:0];
            end
            return {120'd0, acc8};
         end
         xs = x;
         // scan y from its top bit; reduce when a one drops off bit 0
         for (int k = 0; k < 128; k++) begin
            if (y[127-k]) acc ^= xs;
            carry = xs[0];
            xs    = xs >> 1;
            if (carry) xs ^= poly;
         end
         return acc;
      endfunction

      function void note_operands(bit [127:0] x, bit [127:0] y);
         expected_products.push_back(field_product(x, y));
      endfunction

      function void check_product(bit [63:0] got_hi, bit [63:0] got_lo);
         bit [127:0] want;
         if (expected_products.size() == 0) begin
            errors++;
            $display("%0t: unexpected product %h_%h", $time, got_hi, got_lo);
            return;
         end
         want = expected_products.pop_front();
         if (got_hi !== want[127:64]) begin
            errors++;
            $display("%0t: prod_hi expected %h actual %h", $time, want[127:64], got_hi);
         end
         if (got_lo !== want[63:0]) begin
            errors++;
            $display("%0t: prod_lo expected %h actual %h", $time, want[63:0], got_lo);
         end
      endfunction

      function int pending();
         return expected_products.size();
      endfunction

      function void check_drained();
         if (expected_products.size() != 0) begin
            errors++;
            $display("%0t: %0d products never arrived", $time, expected_products.size());
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [gfm_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [gfm_pkg::HALF_BITS-1:0]    csr_wr_data;
   logic product_ready = 1'b0;
   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;
   int   cycle_count = 0;
   gf_product_board board;

   gfm_req_if req_bus();
   gfm_rsp_if rsp_bus();

   assign rsp_bus.ready = product_ready;

   galois_field_multiplier i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      product_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            board.note_operands({req_bus.x_hi, req_bus.x_lo}, {req_bus.y_hi, req_bus.y_lo});
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            board.check_product(rsp_bus.prod_hi, rsp_bus.prod_lo);
         end
      end
   end

   function automatic logic [63:0] operand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(63);
         3: return ~(64'd1 << $urandom_range(63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // leave valid high on return so back-to-back items need no extra edge
   task automatic send_operands(logic [127:0] x, logic [127:0] y);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.x_hi  <= x[127:64];
      req_bus.x_lo  <= x[63:0];
      req_bus.y_hi  <= y[127:64];
      req_bus.y_lo  <= y[63:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [gfm_pkg::CSR_IDX_BITS-1:0] idx, logic [63:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      board.set_reg(idx, value);
   endtask

   // also hit the spare index, which must change nothing
   task automatic configure(logic [63:0] mode_word, logic [63:0] poly_hi,
                            logic [63:0] poly_lo);
      write_reg(gfm_pkg::CSR_FIELD_MODE, mode_word);
      write_reg(gfm_pkg::CSR_POLY_HI, poly_hi);
      write_reg(CSR_SPARE_INDEX, {$urandom, $urandom});
      write_reg(gfm_pkg::CSR_POLY_LO, poly_lo);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [63:0] mode_word;
      board = new();
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= gfm_pkg::CSR_FIELD_MODE;
      csr_wr_data       <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.x_hi      <= '0;
      req_bus.x_lo      <= '0;
      req_bus.y_hi      <= '0;
      req_bus.y_lo      <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // wide mode with the register defaults
      send_operands('0, '0);
      send_operands('1, '1);
      send_operands('1, '0);
      send_operands({64'h8000_0000_0000_0000, 64'd0}, {$urandom, $urandom, $urandom, $urandom});
      send_operands(128'd1, '1);
      send_operands({$urandom, $urandom, $urandom, $urandom}, {64'h8000_0000_0000_0000, 64'd0});
      send_operands(128'd1, 128'd1);
      settle();

      // byte mode with a zero polynomial: overflow just drops off
      configure(64'hFFFF_FFFF_FFFF_FFFE, '1, '0);
      send_operands({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF80},
                    {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF02});
      send_operands('1, '1);
      settle();

      // byte mode, AES polynomial with junk in the unused bits
      configure('0, '1, 64'hFFFF_FFFF_FFFF_FF00 | AES_POLY_LO);
      send_operands(128'h53, 128'hCA);
      send_operands(128'h57, 128'h83);
      send_operands(128'hFF, 128'hFF);
      send_operands({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00}, '1);
      send_operands(128'h80, 128'h80);
      send_operands('1, '0);
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase / 2)
            0: begin req_idle_pct = 29; rsp_idle_pct = 80; end
            1: begin req_idle_pct = 80; rsp_idle_pct = 29; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         mode_word    = {$urandom, $urandom};
         mode_word[0] = (phase % 2 == 0);
         case (phase)
            0: configure(mode_word, GHASH_POLY_HI, '0);
            1: configure(mode_word, operand_word(), {$urandom, 24'd0, AES_POLY_LO[7:0]});
            2: configure(mode_word, '1, '1);
            3: configure(mode_word, '0, '1);
            4: configure(mode_word, operand_word(), operand_word());
            default: configure(mode_word, operand_word(), operand_word());
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_operands({operand_word(), operand_word()}, {operand_word(), operand_word()});
         end
         settle();
      end

      board.check_drained();
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
